[sv/tkst_pkg.sv]
// shared types and constants for the top-k slowest tracker
`default_nettype none
package tkst_pkg;

    // fixed field widths of the item channels
    localparam int OP_W     = 2;
    localparam int NODE_W   = 32;
    localparam int BUCKET_W = 4;
    localparam int IN_TIME_W = 32;
    localparam int RIDX_W   = 3;
    localparam int PLACED_W = 3;
    localparam int COUNT_W  = 4;

    // configuration port
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam logic [APB_ADDR_W-1:0] REG_PROF_EN_ADDR = 3'd0;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic clr;
    } t_cell_ctrl;

endpackage
`default_nettype wire

[sv/tkst_in_if.sv]
// input item channel of the tracker
`default_nettype none
interface tkst_in_if;
    import tkst_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [NODE_W-1:0]    node_id;
    logic [BUCKET_W-1:0]  bucket;
    logic [IN_TIME_W-1:0] elapsed_time;
    logic [RIDX_W-1:0]    read_index;

    modport source (output valid, operation, node_id, bucket, elapsed_time, read_index,
                    input ready);
    modport sink (input valid, operation, node_id, bucket, elapsed_time, read_index,
                  output ready);
endinterface
`default_nettype wire

[sv/tkst_out_if.sv]
// result item channel of the tracker
`default_nettype none
interface tkst_out_if;
    import tkst_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic [PLACED_W-1:0]  placed_at;
    logic [COUNT_W-1:0]   entry_count;
    logic [NODE_W-1:0]    read_node;
    logic [BUCKET_W-1:0]  read_bucket;
    logic [IN_TIME_W-1:0] read_time;

    modport source (output valid, accepted, placed_at, entry_count, read_node, read_bucket,
                    read_time, input ready);
    modport sink (input valid, accepted, placed_at, entry_count, read_node, read_bucket,
                  read_time, output ready);
endinterface
`default_nettype wire

[sv/tkst_cell.sv]
// one slot of the sorted list: holds an entry, compares and shifts toward its neighbor
`default_nettype none
module tkst_cell #(
    parameter int TIME_BITS = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire tkst_pkg::t_cell_ctrl      i_ctrl,
    input  wire [tkst_pkg::NODE_W-1:0]     i_node,
    input  wire [tkst_pkg::BUCKET_W-1:0]   i_bucket,
    input  wire [TIME_BITS-1:0]            i_time,
    input  wire                            i_prev_valid,
    input  wire                            i_prev_keep,
    input  wire [tkst_pkg::NODE_W-1:0]     i_prev_node,
    input  wire [tkst_pkg::BUCKET_W-1:0]   i_prev_bucket,
    input  wire [TIME_BITS-1:0]            i_prev_time,
    output logic                           o_valid,
    output logic                           o_keep,
    output logic [tkst_pkg::NODE_W-1:0]    o_node,
    output logic [tkst_pkg::BUCKET_W-1:0]  o_bucket,
    output logic [TIME_BITS-1:0]           o_time
);
    import tkst_pkg::*;

    logic                r_valid;
    logic [NODE_W-1:0]   r_node;
    logic [BUCKET_W-1:0] r_bucket;
    logic [TIME_BITS-1:0] r_time;

    // entry stays where it is when it is at least as slow as the new record
    assign o_keep = r_valid && (r_time >= i_time);

    // valid bit: cleared by reset and clear, set or shifted on insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.ins && !o_keep) begin
            r_valid <= i_prev_keep ? 1'b1 : i_prev_valid;
        end
    end

    // payload: take the new record at the insert point, the neighbor's entry below it
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && !i_ctrl.clr && !o_keep) begin
            if (i_prev_keep) begin
                r_node   <= i_node;
                r_bucket <= i_bucket;
                r_time   <= i_time;
            end else begin
                r_node   <= i_prev_node;
                r_bucket <= i_prev_bucket;
                r_time   <= i_prev_time;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_node   = r_node;
    assign o_bucket = r_bucket;
    assign o_time   = r_time;
endmodule
`default_nettype wire

[sv/top_k_slowest_tracker_unit.sv]
// top-k slowest tracker: row of compare-and-shift cells behind an item handshake
// Keeps the DEPTH slowest timing records sorted from largest to smallest time.
// Input channel i_in carries one operation per item: record, read or clear.
// Output channel o_out returns exactly one result item for every input item:
// acceptance and insert position of a record, the entry count after the
// operation, and the entry read by a read operation (zeros otherwise).
// The result is registered at the edge that accepts the item. Throughput is one
// item per cycle while o_out does not stall; every cell of the row compares the
// new time against its own entry and shifts in parallel, so an insert is done
// in the accepting cycle. If o_out stalls, the result register holds and
// i_in.ready drops until the result is taken; nothing is lost or repeated.
// Reset (synchronous, active low) empties the list, clears the output
// valid bit and turns profiling off. The APB port holds one register at byte
// address 0 (bit 0: profiling enable); write it only while the block is idle.
`default_nettype none
module top_k_slowest_tracker_unit #(
    parameter int DEPTH     = 8,
    parameter int TIME_BITS = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    tkst_in_if.sink                            i_in,
    tkst_out_if.source                         o_out,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [tkst_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire [tkst_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tkst_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import tkst_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 r_prof_en;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic                 r_out_valid;
    logic                 r_accepted;
    logic [PLACED_W-1:0]  r_placed;
    logic [COUNT_W-1:0]   r_entry_count;
    logic [NODE_W-1:0]    r_rnode;
    logic [BUCKET_W-1:0]  r_rbucket;
    logic [IN_TIME_W-1:0] r_rtime;

    logic                 w_fire;
    logic [TIME_BITS-1:0] w_time;
    logic                 w_accept;
    t_cell_ctrl           w_ctrl;
    logic [PLACED_W-1:0]  w_placed;
    logic [NODE_W-1:0]    w_rnode;
    logic [BUCKET_W-1:0]  w_rbucket;
    logic [TIME_BITS-1:0] w_rtime;

    logic [DEPTH-1:0]     w_valid;
    logic [DEPTH-1:0]     w_keep;
    logic [NODE_W-1:0]    w_node   [DEPTH];
    logic [BUCKET_W-1:0]  w_bucket [DEPTH];
    logic [TIME_BITS-1:0] w_etime  [DEPTH];

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prof_en <= 1'b0;
        end else if (psel && penable && pwrite && paddr == REG_PROF_EN_ADDR) begin
            r_prof_en <= pwdata[0];
        end
    end
    assign prdata = (paddr == REG_PROF_EN_ADDR) ? APB_DATA_W'(r_prof_en) : '0;

    // handshake: take a new item whenever the result register is free or drains
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_time     = TIME_BITS'(i_in.elapsed_time);

    // a record goes in unless ignored or the list is full of equal or slower entries
    assign w_accept = w_fire && (i_in.operation == OP_RECORD) && r_prof_en
                      && (i_in.node_id != '0) && (w_time != '0) && !w_keep[DEPTH-1];
    assign w_ctrl.ins = w_accept;
    assign w_ctrl.clr = w_fire && (i_in.operation == OP_CLEAR);

    // row of cells, each fed by its upper neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 w_pv;
        logic                 w_pk;
        logic [NODE_W-1:0]    w_pn;
        logic [BUCKET_W-1:0]  w_pb;
        logic [TIME_BITS-1:0] w_pt;
        if (g == 0) begin : g_head
            assign w_pv = 1'b0;
            assign w_pk = 1'b1;
            assign w_pn = '0;
            assign w_pb = '0;
            assign w_pt = '0;
        end else begin : g_body
            assign w_pv = w_valid[g-1];
            assign w_pk = w_keep[g-1];
            assign w_pn = w_node[g-1];
            assign w_pb = w_bucket[g-1];
            assign w_pt = w_etime[g-1];
        end
        tkst_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_node        (i_in.node_id),
            .i_bucket      (i_in.bucket),
            .i_time        (w_time),
            .i_prev_valid  (w_pv),
            .i_prev_keep   (w_pk),
            .i_prev_node   (w_pn),
            .i_prev_bucket (w_pb),
            .i_prev_time   (w_pt),
            .o_valid       (w_valid[g]),
            .o_keep        (w_keep[g]),
            .o_node        (w_node[g]),
            .o_bucket      (w_bucket[g]),
            .o_time        (w_etime[g])
        );
    end

    // insert position: the first cell that does not keep its entry
    always_comb begin
        w_placed = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (!w_keep[i] && (i == 0 || w_keep[(i > 0) ? i - 1 : 0])) begin
                w_placed = w_placed | PLACED_W'(i);
            end
        end
    end

    // read select: only valid cells answer, so an index past the count reads zeros
    always_comb begin
        w_rnode   = '0;
        w_rbucket = '0;
        w_rtime   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (32'(i_in.read_index) == i && w_valid[i]) begin
                w_rnode   = w_node[i];
                w_rbucket = w_bucket[i];
                w_rtime   = w_etime[i];
            end
        end
    end

    // entry count after the operation
    always_comb begin
        n_count = r_count;
        if (w_ctrl.clr) begin
            n_count = '0;
        end else if (w_accept && r_count != CNT_W'(DEPTH)) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_accepted    <= w_accept;
            r_placed      <= w_accept ? w_placed : '0;
            r_entry_count <= COUNT_W'(n_count);
            if (i_in.operation == OP_READ) begin
                r_rnode   <= w_rnode;
                r_rbucket <= w_rbucket;
                r_rtime   <= IN_TIME_W'(w_rtime);
            end else begin
                r_rnode   <= '0;
                r_rbucket <= '0;
                r_rtime   <= '0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.accepted    = r_accepted;
    assign o_out.placed_at   = r_placed;
    assign o_out.entry_count = r_entry_count;
    assign o_out.read_node   = r_rnode;
    assign o_out.read_bucket = r_rbucket;
    assign o_out.read_time   = r_rtime;

    // count never exceeds the list depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // valid cells match the count
    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("valid cells disagree with count");

    // a clear empties the row
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clr |=> (r_count == '0 && w_valid == '0))
        else $error("list not empty after clear");

endmodule
`default_nettype wire

[dv/tb_top.sv]
// self-checking testbench for the top-k slowest tracker unit
`timescale 1ns / 1ps
module tb_top;
    import tkst_pkg::*;

    localparam int TRACK_DEPTH = 8;
    // code that the block leaves without effect
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [NODE_W-1:0]    node;
        logic [BUCKET_W-1:0]  bucket;
        logic [IN_TIME_W-1:0] elapsed;
        logic [RIDX_W-1:0]    ridx;
    } t_tracker_item;

    typedef struct packed {
        logic                 accepted;
        logic [PLACED_W-1:0]  placed_at;
        logic [COUNT_W-1:0]   entry_count;
        logic [NODE_W-1:0]    read_node;
        logic [BUCKET_W-1:0]  read_bucket;
        logic [IN_TIME_W-1:0] read_time;
    } t_tracker_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tkst_in_if  in_ch ();
    tkst_out_if out_ch ();

    top_k_slowest_tracker_unit #(
        .DEPTH     (TRACK_DEPTH),
        .TIME_BITS (32)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the sorted list
    logic [NODE_W-1:0]    slot_node [TRACK_DEPTH];
    logic [BUCKET_W-1:0]  slot_bucket [TRACK_DEPTH];
    logic [IN_TIME_W-1:0] slot_time [TRACK_DEPTH];
    int                   live_count = 0;
    logic                 prof_en = 1'b0;

    t_tracker_item   pending_items[$];
    t_tracker_result expected_results[$];
    t_tracker_item   cur_item;
    bit              item_held = 1'b0;
    int              items_sent = 0;
    int              results_seen = 0;
    int              mismatch_cnt = 0;
    int              hold_left = 0;
    bit              pressure_done = 1'b0;

    // clock and reset
    always #10 i_clk = ~i_clk;

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.operation    = '0;
        in_ch.node_id      = '0;
        in_ch.bucket       = '0;
        in_ch.elapsed_time = '0;
        in_ch.read_index   = '0;
        out_ch.ready       = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        for (int i = 0; i < TRACK_DEPTH; i++) begin
            slot_node[i]   = '0;
            slot_bucket[i] = '0;
            slot_time[i]   = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic string fmt_result(t_tracker_result r);
        return $sformatf("acc=%0d pos=%0d cnt=%0d node=%h bkt=%0d time=%h",
                         r.accepted, r.placed_at, r.entry_count, r.read_node,
                         r.read_bucket, r.read_time);
    endfunction

    task automatic flag_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("ERROR: %s", msg);
        end
    endtask

    // apply one operation to the shadow list and return its result
    function automatic t_tracker_result track_item(t_tracker_item it);
        t_tracker_result r;
        int              pos;
        bit              ok;
        r = '0;
        case (it.op)
            OP_RECORD: begin
                if (prof_en && it.node != 0 && it.elapsed != 0) begin
                    pos = live_count;
                    ok  = 1'b1;
                    if (pos < TRACK_DEPTH) begin
                        live_count++;
                    end else if (it.elapsed <= slot_time[TRACK_DEPTH-1]) begin
                        ok = 1'b0;
                    end else begin
                        pos = TRACK_DEPTH - 1;
                    end
                    if (ok) begin
                        // shift smaller entries down, stop behind equal times
                        while (pos > 0 && slot_time[pos-1] < it.elapsed) begin
                            slot_node[pos]   = slot_node[pos-1];
                            slot_bucket[pos] = slot_bucket[pos-1];
                            slot_time[pos]   = slot_time[pos-1];
                            pos--;
                        end
                        slot_node[pos]   = it.node;
                        slot_bucket[pos] = it.bucket;
                        slot_time[pos]   = it.elapsed;
                        r.accepted  = 1'b1;
                        r.placed_at = pos[PLACED_W-1:0];
                    end
                end
            end
            OP_READ: begin
                if (int'(it.ridx) < live_count) begin
                    r.read_node   = slot_node[it.ridx];
                    r.read_bucket = slot_bucket[it.ridx];
                    r.read_time   = slot_time[it.ridx];
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < TRACK_DEPTH; i++) begin
                    slot_node[i]   = '0;
                    slot_bucket[i] = '0;
                    slot_time[i]   = '0;
                end
                live_count = 0;
            end
            default: ;
        endcase
        r.entry_count = live_count[COUNT_W-1:0];
        return r;
    endfunction

    // item driver: one item in flight, random gaps outside the gapless window
    always @(posedge i_clk) begin : drv
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(track_item(cur_item));
                items_sent++;
                item_held = 1'b0;
            end
            if (!item_held) begin
                if (pending_items.size() != 0 &&
                    ((items_sent >= 450 && items_sent < 600) || $urandom_range(99) >= 24)) begin
                    cur_item  = pending_items.pop_front();
                    item_held = 1'b1;
                    in_ch.operation    <= cur_item.op;
                    in_ch.node_id      <= cur_item.node;
                    in_ch.bucket       <= cur_item.bucket;
                    in_ch.elapsed_time <= cur_item.elapsed;
                    in_ch.read_index   <= cur_item.ridx;
                    in_ch.valid        <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls and one long hold-off
    always @(posedge i_clk) begin : mon
        t_tracker_result got;
        t_tracker_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.accepted    = out_ch.accepted;
                got.placed_at   = out_ch.placed_at;
                got.entry_count = out_ch.entry_count;
                got.read_node   = out_ch.read_node;
                got.read_bucket = out_ch.read_bucket;
                got.read_time   = out_ch.read_time;
                results_seen++;
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("result with nothing pending: %s", fmt_result(got)));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        flag_error($sformatf("result %0d\n  exp %s\n  got %s",
                                             results_seen, fmt_result(want), fmt_result(got)));
                    end
                end
            end
            if (!pressure_done && results_seen >= 300) begin
                hold_left     = 64;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= (results_seen >= 450 && results_seen < 600) ||
                                $urandom_range(99) >= 24;
            end
        end
    end

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] node,
                              input logic [BUCKET_W-1:0] bkt,
                              input logic [IN_TIME_W-1:0] t, input logic [RIDX_W-1:0] ridx);
        t_tracker_item it;
        it.op      = op;
        it.node    = node;
        it.bucket  = bkt;
        it.elapsed = t;
        it.ridx    = ridx;
        pending_items.push_back(it);
    endtask

    // mostly records with clustered times so ties and replacement happen often
    function automatic t_tracker_item rand_item();
        t_tracker_item it;
        int            sel;
        sel       = $urandom_range(99);
        it.node   = $urandom;
        it.bucket = ($urandom_range(7) == 0) ? BUCKET_W'($urandom_range(15, 9))
                                             : BUCKET_W'($urandom_range(8, 0));
        it.ridx   = RIDX_W'($urandom_range(7, 0));
        case ($urandom_range(3))
            0, 1:    it.elapsed = $urandom_range(40, 1);
            2:       it.elapsed = $urandom;
            default: it.elapsed = 32'hFFFF_FFFF - $urandom_range(3, 0);
        endcase
        if (sel < 64) begin
            it.op = OP_RECORD;
        end else if (sel < 90) begin
            it.op = OP_READ;
        end else if (sel < 93) begin
            it.op = OP_CLEAR;
        end else if (sel < 96) begin
            it.op = OP_NONE;
        end else begin
            // record that must be ignored
            it.op = OP_RECORD;
            if ($urandom_range(1)) begin
                it.node = '0;
            end else begin
                it.elapsed = '0;
            end
        end
        return it;
    endfunction

    // wait until every queued item has been accepted and answered
    task automatic drain_tracker();
        while (pending_items.size() != 0 || item_held || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    // write the enable register over apb, then read it back
    task automatic set_profiling(input logic en);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_PROF_EN_ADDR;
        pwdata  <= {{(APB_DATA_W-1){1'b0}}, en};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        prof_en = en;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== en) begin
            flag_error($sformatf("profiling enable readback exp %0d got %0d", en, prdata[0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stimulus
    initial begin : stim
        int unsigned chunk_len[6]  = '{180, 60, 170, 170, 170, 150};
        bit          chunk_prof[6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        // profiling still off after reset: record is ignored
        queue_item(OP_RECORD, 32'd5, 4'd1, 32'd50, 3'd0);
        queue_item(OP_READ, 32'd0, 4'd0, 32'd0, 3'd0);
        queue_item(OP_NONE, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 3'd7);
        drain_tracker();
        set_profiling(1'b1);

        // null node and zero time are ignored
        queue_item(OP_RECORD, 32'd0, 4'd1, 32'd10, 3'd0);
        queue_item(OP_RECORD, 32'd7, 4'd1, 32'd0, 3'd0);
        // fill the list with extremes and ties
        queue_item(OP_RECORD, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 3'd0);
        queue_item(OP_RECORD, 32'd1, 4'd0, 32'd1, 3'd0);
        queue_item(OP_RECORD, 32'd2, 4'd8, 32'd100, 3'd0);
        queue_item(OP_RECORD, 32'd3, 4'd2, 32'd100, 3'd0);
        queue_item(OP_RECORD, 32'd4, 4'd3, 32'd50, 3'd0);
        queue_item(OP_RECORD, 32'd5, 4'd4, 32'd100, 3'd0);
        queue_item(OP_RECORD, 32'd6, 4'd5, 32'd20, 3'd0);
        queue_item(OP_RECORD, 32'd8, 4'd6, 32'd2, 3'd0);
        // full list: equal to last is dropped, larger replaces last and moves up
        queue_item(OP_RECORD, 32'd9, 4'd7, 32'd1, 3'd0);
        queue_item(OP_RECORD, 32'd11, 4'd9, 32'd3, 3'd0);
        queue_item(OP_RECORD, 32'd12, 4'd8, 32'd100, 3'd0);
        for (int i = 0; i < TRACK_DEPTH; i++) begin
            queue_item(OP_READ, 32'd0, 4'd0, 32'd0, i[RIDX_W-1:0]);
        end
        queue_item(OP_NONE, 32'd0, 4'd0, 32'd0, 3'd0);
        // clear then read beyond the count
        queue_item(OP_CLEAR, 32'd0, 4'd0, 32'd0, 3'd0);
        queue_item(OP_READ, 32'd0, 4'd0, 32'd0, 3'd0);
        queue_item(OP_RECORD, 32'd13, 4'd1, 32'd5, 3'd0);
        drain_tracker();

        // random phases under both enable settings
        for (int c = 0; c < 6; c++) begin
            set_profiling(chunk_prof[c]);
            for (int unsigned n = 0; n < chunk_len[c]; n++) begin
                pending_items.push_back(rand_item());
            end
            drain_tracker();
        end

        repeat (5) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
